[rtl/los_wf_pkg.sv]
`default_nettype none
package los_wf_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	localparam logic [1:0] REG_NAV_GAIN    = 2'd0;
	localparam logic [1:0] REG_ARRIVAL_TOL = 2'd1;
	localparam logic [1:0] REG_LINEAR_SPD  = 2'd2;
	localparam logic [1:0] REG_TICK_RATE   = 2'd3;

	localparam int ATAN_ENTRIES = 20;
	localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [16:0] PI_Q13      = 17'sd25736;

	// shift-add multiplier operand width and cordic datapath width
	localparam int MW = 26;
	localparam int XW = 56;

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_DIST  = 15'b000000000000010,
		S_SQT   = 15'b000000000000100,
		S_SQX   = 15'b000000000001000,
		S_SQY   = 15'b000000000010000,
		S_CMP   = 15'b000000000100000,
		S_RD    = 15'b000000001000000,
		S_LOAD  = 15'b000000010000000,
		S_CINIT = 15'b000000100000000,
		S_CORD  = 15'b000001000000000,
		S_GSET  = 15'b000010000000000,
		S_GR    = 15'b000100000000000,
		S_MUL   = 15'b001000000000000,
		S_FIN   = 15'b010000000000000,
		S_OUT   = 15'b100000000000000
	} state_t;

	function automatic logic signed [16:0] atan_q13(input logic [4:0] i);
		logic signed [16:0] r;
		case (i)
			5'd0:    r = 17'sd6434;
			5'd1:    r = 17'sd3798;
			5'd2:    r = 17'sd2007;
			5'd3:    r = 17'sd1019;
			5'd4:    r = 17'sd511;
			5'd5:    r = 17'sd256;
			5'd6:    r = 17'sd128;
			5'd7:    r = 17'sd64;
			5'd8:    r = 17'sd32;
			5'd9:    r = 17'sd16;
			5'd10:   r = 17'sd8;
			5'd11:   r = 17'sd4;
			5'd12:   r = 17'sd2;
			5'd13:   r = 17'sd1;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/los_rate_waypoint_follower.sv]
`default_nettype none
// Waypoint follower with proportional-navigation steering. cmd 0 clears the
// waypoint table, cmd 1 appends (pos_x, pos_y), cmd 2 is a control tick with
// the robot position; every accepted item gives exactly one result. Items are
// handled one at a time: in_ready stays low from a transfer until its result
// is loaded into the output register, which waits while an earlier result is
// still held there. A tick runs a shift-add multiplier one bit per cycle and an
// iterative CORDIC one rotation per cycle; the arrival check, which squares
// distances with the multiplier, is skipped when the goal lies 2^24 or more
// away on either axis. The table is a memory of MAX_WAYPOINTS entries
// with one write port and a registered read.
module los_rate_waypoint_follower #(
	parameter int MAX_WAYPOINTS     = 64,
	parameter int CORDIC_ITERATIONS = 14
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [3:0]         paddr,
	input  wire  [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [1:0]         cmd,
	input  wire  signed [31:0] pos_x,
	input  wire  signed [31:0] pos_y,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [19:0]        linear_velocity,
	output logic signed [31:0] angular_velocity,
	output logic               active,
	output logic               finished
);
	import los_wf_pkg::*;

	localparam int IW  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int CW  = IW + 1;
	localparam int NIT = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS
		: ATAN_ENTRIES;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WAYPOINTS);

	state_t state_q;

	logic [15:0] nav_gain_q;
	logic [23:0] tol_q;
	logic [19:0] lin_spd_q;
	logic [9:0]  tick_rate_q;

	logic [63:0] mem [MAX_WAYPOINTS];
	logic [63:0] rd_q;

	logic [CW-1:0] count_q, next_q;
	logic signed [31:0] goal_x_q, goal_y_q, px_q, py_q;
	logic following_q;
	logic signed [15:0] prev_q, ang_q;

	logic signed [32:0] dx_q, dy_q;
	logic [23:0] ax_q, ay_q;
	logic [47:0] tt_q;

	logic [2*MW-1:0] mul_a_q, mul_acc_q;
	logic [MW-1:0]   mul_b_q;
	logic [4:0]      mcnt_q;
	logic            neg_q;

	logic signed [XW-1:0] cx_q, cy_q;
	logic signed [16:0]   cz_q;
	logic [4:0]           it_q;

	logic [19:0]        res_lin_q;
	logic signed [31:0] res_ang_q;
	logic               res_act_q, res_fin_q;

	logic signed [32:0] dx_c, dy_c;
	logic [32:0]        ax_c, ay_c;
	logic signed [XW-1:0] cx0_c, cy0_c, xs_c, ys_c;
	logic signed [16:0] diff_c;
	logic [16:0]        adiff_c;
	logic signed [43:0] p_c;
	logic signed [38:0] r_c;
	logic [IW-1:0]      wr_addr, rd_addr;
	logic               wr_en;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		case (paddr[3:2])
			REG_NAV_GAIN:    prdata = {16'd0, nav_gain_q};
			REG_ARRIVAL_TOL: prdata = {8'd0, tol_q};
			REG_LINEAR_SPD:  prdata = {12'd0, lin_spd_q};
			REG_TICK_RATE:   prdata = {22'd0, tick_rate_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nav_gain_q  <= 16'd256;
			tol_q       <= 24'd65536;
			lin_spd_q   <= 20'd6554;
			tick_rate_q <= 10'd50;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_NAV_GAIN:    nav_gain_q  <= pwdata[15:0];
				REG_ARRIVAL_TOL: tol_q       <= pwdata[23:0];
				REG_LINEAR_SPD:  lin_spd_q   <= pwdata[19:0];
				REG_TICK_RATE:   tick_rate_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// waypoint table
	assign wr_addr = count_q[IW-1:0];
	assign rd_addr = next_q[IW-1:0];
	assign wr_en   = in_valid && in_ready && (cmd == CMD_APPEND) && (count_q < MAX_CNT);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {pos_x, pos_y};
		end
		rd_q <= mem[rd_addr];
	end

	assign dx_c = {goal_x_q[31], goal_x_q} - {px_q[31], px_q};
	assign dy_c = {goal_y_q[31], goal_y_q} - {py_q[31], py_q};
	assign ax_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
	assign ay_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);

	assign cx0_c = XW'(dx_q) <<< 20;
	assign cy0_c = XW'(dy_q) <<< 20;
	assign xs_c  = cx_q >>> it_q;
	assign ys_c  = cy_q >>> it_q;

	assign diff_c  = {ang_q[15], ang_q} - {prev_q[15], prev_q};
	assign adiff_c = diff_c[16] ? 17'(-diff_c) : 17'(diff_c);
	assign p_c     = neg_q ? -$signed({1'b0, mul_acc_q[42:0]})
		: $signed({1'b0, mul_acc_q[42:0]});
	assign r_c     = 39'((p_c + 44'sd16) >>> 5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			next_q      <= '0;
			goal_x_q    <= '0;
			goal_y_q    <= '0;
			following_q <= 1'b0;
			prev_q      <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						px_q      <= pos_x;
						py_q      <= pos_y;
						res_lin_q <= '0;
						res_ang_q <= '0;
						res_fin_q <= 1'b0;
						case (cmd)
							CMD_CLEAR: begin
								count_q     <= '0;
								next_q      <= '0;
								following_q <= 1'b0;
								res_act_q   <= 1'b0;
								state_q     <= S_OUT;
							end
							CMD_APPEND: begin
								res_act_q <= following_q || (count_q == '0);
								state_q   <= S_OUT;
								if (count_q < MAX_CNT) begin
									if (count_q == '0) begin
										goal_x_q    <= pos_x;
										goal_y_q    <= pos_y;
										next_q      <= CW'(1);
										following_q <= 1'b1;
									end
									count_q <= count_q + CW'(1);
								end
							end
							CMD_TICK: begin
								res_act_q <= following_q;
								state_q   <= following_q ? S_DIST : S_OUT;
							end
							default: begin
								res_act_q <= following_q;
								state_q   <= S_OUT;
							end
						endcase
					end
				end
				S_DIST: begin
					dx_q <= dx_c;
					dy_q <= dy_c;
					ax_q <= ax_c[23:0];
					ay_q <= ay_c[23:0];
					if (ax_c[32:24] != '0 || ay_c[32:24] != '0) begin
						state_q <= S_CINIT;
					end else begin
						mul_a_q   <= (2*MW)'(tol_q);
						mul_b_q   <= MW'(tol_q);
						mul_acc_q <= '0;
						mcnt_q    <= 5'(MW);
						state_q   <= S_SQT;
					end
				end
				S_SQT, S_SQX, S_SQY, S_GR, S_MUL: begin
					if (mcnt_q != '0) begin
						if (mul_b_q[0]) begin
							mul_acc_q <= mul_acc_q + mul_a_q;
						end
						mul_a_q <= mul_a_q << 1;
						mul_b_q <= mul_b_q >> 1;
						mcnt_q  <= mcnt_q - 5'd1;
					end else begin
						mcnt_q <= 5'(MW);
						case (state_q)
							S_SQT: begin
								tt_q      <= mul_acc_q[47:0];
								mul_acc_q <= '0;
								mul_a_q   <= (2*MW)'(ax_q);
								mul_b_q   <= MW'(ax_q);
								state_q   <= S_SQX;
							end
							S_SQX: begin
								// keep the sum: ay squared adds onto ax squared
								mul_a_q <= (2*MW)'(ay_q);
								mul_b_q <= MW'(ay_q);
								state_q <= S_SQY;
							end
							S_SQY: state_q <= S_CMP;
							S_GR: begin
								mul_a_q   <= (2*MW)'(mul_acc_q[MW-1:0]);
								mul_b_q   <= MW'(adiff_c);
								neg_q     <= diff_c[16];
								prev_q    <= ang_q;
								mul_acc_q <= '0;
								state_q   <= S_MUL;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_CMP: begin
					if (mul_acc_q[48:0] < {1'b0, tt_q}) begin
						if (next_q >= count_q || next_q >= MAX_CNT) begin
							following_q <= 1'b0;
							res_act_q   <= 1'b0;
							res_fin_q   <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end else begin
						state_q <= S_CINIT;
					end
				end
				S_RD: state_q <= S_LOAD;
				S_LOAD: begin
					goal_x_q <= rd_q[63:32];
					goal_y_q <= rd_q[31:0];
					next_q   <= next_q + CW'(1);
					state_q  <= S_DIST;
				end
				S_CINIT: begin
					it_q <= '0;
					if (dx_q == '0 && dy_q == '0) begin
						ang_q   <= '0;
						state_q <= S_GSET;
					end else begin
						state_q <= S_CORD;
						if (dx_q[32]) begin
							if (!dy_q[32]) begin
								cx_q <= cy0_c;
								cy_q <= -cx0_c;
								cz_q <= HALF_PI_Q13;
							end else begin
								cx_q <= -cy0_c;
								cy_q <= cx0_c;
								cz_q <= -HALF_PI_Q13;
							end
						end else begin
							cx_q <= cx0_c;
							cy_q <= cy0_c;
							cz_q <= '0;
						end
					end
				end
				S_CORD: begin
					if (it_q == 5'(NIT)) begin
						if (cz_q > PI_Q13) begin
							ang_q <= 16'(PI_Q13);
						end else if (cz_q < -PI_Q13) begin
							ang_q <= 16'(-PI_Q13);
						end else begin
							ang_q <= cz_q[15:0];
						end
						state_q <= S_GSET;
					end else begin
						if (!cy_q[XW-1]) begin
							cx_q <= cx_q + ys_c;
							cy_q <= cy_q - xs_c;
							cz_q <= cz_q + atan_q13(it_q);
						end else begin
							cx_q <= cx_q - ys_c;
							cy_q <= cy_q + xs_c;
							cz_q <= cz_q - atan_q13(it_q);
						end
						it_q <= it_q + 5'd1;
					end
				end
				S_GSET: begin
					mul_a_q   <= (2*MW)'(nav_gain_q);
					mul_b_q   <= MW'(tick_rate_q);
					mul_acc_q <= '0;
					mcnt_q    <= 5'(MW);
					state_q   <= S_GR;
				end
				S_FIN: begin
					if (r_c > 39'sd2147483647) begin
						res_ang_q <= 32'sh7FFFFFFF;
					end else if (r_c < -39'sd2147483648) begin
						res_ang_q <= 32'sh80000000;
					end else begin
						res_ang_q <= r_c[31:0];
					end
					res_lin_q <= lin_spd_q;
					res_act_q <= 1'b1;
					res_fin_q <= 1'b0;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid || out_ready) begin
						out_valid        <= 1'b1;
						linear_velocity  <= res_lin_q;
						angular_velocity <= res_ang_q;
						active           <= res_act_q;
						finished         <= res_fin_q;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[tb/tb_los_rate_waypoint_follower.sv]
`timescale 1ns / 1ps
module tb_los_rate_waypoint_follower;
	import los_wf_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int TABLE_DEPTH = 64;
	localparam int ROTATIONS = 14;

	typedef struct packed {
		logic [19:0]        lin;
		logic signed [31:0] ang;
		logic               act;
		logic               fin;
	} steer_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	wire [31:0] prdata;
	wire pready;
	logic in_valid;
	wire in_ready;
	logic [1:0] cmd;
	logic signed [31:0] pos_x, pos_y;
	wire out_valid;
	logic out_ready;
	wire [19:0] linear_velocity;
	wire signed [31:0] angular_velocity;
	wire active, finished;

	los_rate_waypoint_follower u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.linear_velocity(linear_velocity), .angular_velocity(angular_velocity),
		.active(active), .finished(finished)
	);

	// shadow of the follower
	int unsigned gain_q, tol_q, speed_q, rate_q;
	logic signed [31:0] wp_x [TABLE_DEPTH];
	logic signed [31:0] wp_y [TABLE_DEPTH];
	int unsigned wp_count, wp_next;
	longint goal_x, goal_y;
	bit following;
	int prev_angle;

	steer_result_t steer_q [$];
	int errors;
	int stall_left;
	int items_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[los_rate_waypoint_follower] ERROR");
		$finish;
	end

	function automatic bit near_goal(longint dx, longint dy);
		longint ax, ay, t;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		t = tol_q;
		if (ax >= 64'sd16777216 || ay >= 64'sd16777216)
			return 1'b0;
		return ax * ax + ay * ay < t * t;
	endfunction

	function automatic int sight_angle(longint dx, longint dy);
		longint x, y, t, xs, ys;
		int z;
		x = dx * 64'sd1048576;
		y = dy * 64'sd1048576;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = int'(HALF_PI_Q13);
			end else begin
				t = x; x = -y; y = t; z = -int'(HALF_PI_Q13);
			end
		end
		for (int i = 0; i < ROTATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += int'(atan_q13(5'(i)));
			end else begin
				x -= ys; y += xs; z -= int'(atan_q13(5'(i)));
			end
		end
		if (z > int'(PI_Q13)) z = int'(PI_Q13);
		if (z < -int'(PI_Q13)) z = -int'(PI_Q13);
		return z;
	endfunction

	task automatic follow_step(input logic [1:0] c, input logic signed [31:0] px,
			input logic signed [31:0] py, output steer_result_t r);
		bit done;
		int a;
		longint p;
		r = '0;
		if (c == CMD_CLEAR) begin
			wp_count = 0;
			wp_next = 0;
			following = 1'b0;
		end else if (c == CMD_APPEND) begin
			if (wp_count < TABLE_DEPTH) begin
				wp_x[wp_count] = px;
				wp_y[wp_count] = py;
				if (wp_count == 0) begin
					goal_x = px;
					goal_y = py;
					wp_next = 1;
					following = 1'b1;
				end
				wp_count++;
			end
		end else if (c == CMD_TICK && following) begin
			done = 1'b0;
			while (near_goal(goal_x - longint'(px), goal_y - longint'(py))) begin
				if (wp_next >= wp_count) begin
					following = 1'b0;
					r.fin = 1'b1;
					done = 1'b1;
					break;
				end
				goal_x = wp_x[wp_next];
				goal_y = wp_y[wp_next];
				wp_next++;
			end
			if (!done) begin
				a = sight_angle(goal_x - longint'(px), goal_y - longint'(py));
				p = (longint'(a) - longint'(prev_angle)) * longint'(gain_q) * longint'(rate_q);
				prev_angle = a;
				p = (p + 16) >>> 5;
				if (p > 64'sd2147483647) p = 64'sd2147483647;
				if (p < -64'sd2147483648) p = -64'sd2147483648;
				r.ang = p[31:0];
				r.lin = speed_q[19:0];
			end
		end
		r.act = following;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic send_item(input logic [1:0] c, input logic signed [31:0] px,
			input logic signed [31:0] py);
		int gap;
		steer_result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		pos_x <= px;
		pos_y <= py;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		follow_step(c, px, py, r);
		steer_q.insert(steer_q.size(), r);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (steer_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// only called with the follower idle
	task automatic write_reg(input logic [1:0] idx, input int unsigned v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_NAV_GAIN:    gain_q = v & 32'hFFFF;
			REG_ARRIVAL_TOL: tol_q = v & 32'hFF_FFFF;
			REG_LINEAR_SPD:  speed_q = v & 32'hF_FFFF;
			REG_TICK_RATE:   rate_q = v & 32'h3FF;
			default: ;
		endcase
	endtask

	// result checker and receiver pacing
	always @(posedge clk) begin
		steer_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (steer_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result lin=%0d ang=%0d act=%0b fin=%0b",
						linear_velocity, angular_velocity, active, finished);
			end else begin
				e = steer_q.pop_front();
				if (linear_velocity !== e.lin || angular_velocity !== e.ang ||
						active !== e.act || finished !== e.fin) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp lin=%0d ang=%0d act=%0b fin=%0b, got lin=%0d ang=%0d act=%0b fin=%0b",
							e.lin, e.ang, e.act, e.fin,
							linear_velocity, angular_velocity, active, finished);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= pick_gap() == 0;
		end
	end

	task automatic test_directed();
		send_item(CMD_TICK, 32'sd0, 32'sd0);
		send_item(CMD_NOP, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(CMD_CLEAR, 32'sd0, 32'sd0);
		send_item(CMD_APPEND, 32'sd0, 32'sd0);
		// robot on the only waypoint: finish at once
		send_item(CMD_TICK, 32'sd0, 32'sd0);
		send_item(CMD_TICK, 32'sd5, 32'sd5);
		send_item(CMD_APPEND, 32'sd100, 32'sd100);
		send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(CMD_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(CMD_APPEND, 32'sd100000, -32'sd50000);
		send_item(CMD_TICK, 32'sd0, 32'sd0);
		send_item(CMD_TICK, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(CMD_TICK, 32'h7FFF_FFF0, 32'h8000_0010);
		send_item(CMD_NOP, 32'sd1, -32'sd1);
		send_item(CMD_TICK, 32'sd300000, 32'sd200000);
		send_item(CMD_TICK, 32'sd300000, -32'sd200000);
		send_item(CMD_TICK, -32'sd300000, -32'sd200000);
		send_item(CMD_TICK, 32'sd100000, -32'sd50000);
		send_item(CMD_TICK, 32'sd0, 32'sd0);
		drain();
	endtask

	task automatic test_zero_settings();
		write_reg(REG_ARRIVAL_TOL, 0);
		write_reg(REG_TICK_RATE, 0);
		write_reg(REG_NAV_GAIN, 32'hFFFF);
		write_reg(REG_LINEAR_SPD, 32'hF_FFFF);
		send_item(CMD_CLEAR, 32'sd0, 32'sd0);
		send_item(CMD_APPEND, 32'sd5, 32'sd5);
		send_item(CMD_TICK, 32'sd5, 32'sd5);
		send_item(CMD_TICK, -32'sd90000, 32'sd5);
		drain();
		write_reg(REG_TICK_RATE, 1023);
		send_item(CMD_TICK, 32'sd5, -32'sd900000);
		send_item(CMD_TICK, 32'sd5, 32'sd900000);
		drain();
	endtask

	task automatic test_full_table();
		write_reg(REG_ARRIVAL_TOL, 32'hFF_FFFF);
		send_item(CMD_CLEAR, 32'sd0, 32'sd0);
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			send_item(CMD_APPEND, $urandom_range(0, 65535), -$urandom_range(0, 65535));
		// every waypoint lies within tolerance: one tick walks the whole table
		send_item(CMD_TICK, 32'sd1000, -32'sd1000);
		send_item(CMD_TICK, 32'sd1000, -32'sd1000);
		send_item(CMD_APPEND, 32'sd7, 32'sd7);
		drain();
	endtask

	task automatic test_backpressure();
		send_item(CMD_CLEAR, 32'sd0, 32'sd0);
		send_item(CMD_APPEND, 32'sd400000, 32'sd400000);
		drain();
		stall_left = 3000;
		for (int i = 0; i < 10; i++)
			send_item(CMD_TICK, $urandom_range(0, 200000), $urandom_range(0, 200000));
		drain();
	endtask

	task automatic random_config();
		int r;
		r = $urandom_range(0, 3);
		write_reg(REG_NAV_GAIN, r == 0 ? 0 : r == 1 ? 32'hFFFF : r == 2 ? 256 : $urandom);
		r = $urandom_range(0, 4);
		write_reg(REG_ARRIVAL_TOL, r == 0 ? 0 : r == 1 ? 32'hFF_FFFF :
			r == 2 ? 65536 : $urandom_range(1, 262144));
		r = $urandom_range(0, 2);
		write_reg(REG_LINEAR_SPD, r == 0 ? 0 : r == 1 ? 32'hF_FFFF : $urandom);
		r = $urandom_range(0, 5);
		write_reg(REG_TICK_RATE, r == 0 ? 0 : r == 1 ? 1 : r == 2 ? 1000 :
			r == 3 ? 1023 : $urandom_range(1, 1000));
	endtask

	task automatic test_random(input int n_items);
		int stop_at, k, j, off;
		logic signed [31:0] px, py;
		logic signed [31:0] lx [$];
		logic signed [31:0] ly [$];
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			drain();
			random_config();
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 9) != 0) begin
					send_item(CMD_CLEAR, $urandom, $urandom);
					lx.delete();
					ly.delete();
				end
				k = $urandom_range(0, 19) == 0 ? $urandom_range(60, 68) : $urandom_range(1, 6);
				for (int i = 0; i < k; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						px = $urandom;
						py = $urandom;
					end else begin
						px = int'($urandom_range(0, 4194304)) - 2097152;
						py = int'($urandom_range(0, 4194304)) - 2097152;
					end
					lx.insert(lx.size(), px);
					ly.insert(ly.size(), py);
					send_item(CMD_APPEND, px, py);
				end
				repeat ($urandom_range(2, 12)) begin
					if ($urandom_range(0, 1) == 0 && lx.size() != 0) begin
						j = $urandom_range(0, lx.size() - 1);
						off = tol_q > 1 ? int'($urandom_range(0, tol_q)) - int'(tol_q / 2) : 0;
						send_item(CMD_TICK, lx[j] + off, ly[j] - off);
					end else if ($urandom_range(0, 9) == 0) begin
						send_item($urandom_range(0, 3), $urandom, $urandom);
					end else begin
						send_item(CMD_TICK, int'($urandom_range(0, 4194304)) - 2097152,
							int'($urandom_range(0, 4194304)) - 2097152);
					end
				end
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		cmd = CMD_CLEAR;
		pos_x = '0;
		pos_y = '0;
		out_ready = 1'b0;
		errors = 0;
		stall_left = 0;
		items_sent = 0;
		gain_q = 256;
		tol_q = 65536;
		speed_q = 6554;
		rate_q = 50;
		wp_count = 0;
		wp_next = 0;
		goal_x = 0;
		goal_y = 0;
		following = 1'b0;
		prev_angle = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_zero_settings();
		test_full_table();
		write_reg(REG_ARRIVAL_TOL, 65536);
		test_backpressure();
		test_random(1700);
		drain();
		repeat (300) @(posedge clk);
		if (errors == 0 && steer_q.size() == 0)
			$display("[los_rate_waypoint_follower] OK");
		else
			$display("[los_rate_waypoint_follower] ERROR");
		$finish;
	end

endmodule
